@@ src/tccw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET = 7'd25;
	localparam logic [15:0] ATTR_RESET = 16'd7;
	localparam logic [6:0] INDENT_RESET = 7'd0;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_SCREEN_COLS = 2'd0,
		REG_SCREEN_ROWS = 2'd1,
		REG_TEXT_ATTR   = 2'd2,
		REG_INDENT_COL  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [7:0] pos_x;
		logic [6:0] pos_y;
	} in_req_t;

	typedef struct packed {
		logic [7:0]  cell_char;
		logic [15:0] cell_attr;
		logic [7:0]  cursor_col;
		logic [6:0]  cursor_row;
	} out_req_t;

	typedef struct packed {
		logic rdy;
		logic put_wr;
		logic cur_upd;
		logic nl_cur;
		logic fill_ld;
		logic fill_wr;
		logic sweep_wr;
		logic sweep_init;
		logic home;
		logic rd_en;
		logic push;
		logic push_rd;
	} ctl_t;

	typedef struct packed {
		logic room;
		logic is_nl;
		logic at_last;
		logic fill_need;
		logic fill_last;
		logic sweep_last;
	} stat_t;

endpackage

`default_nettype wire

@@ src/tccw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       op,
	input  wire tccw_pkg::stat_t  stat,
	output tccw_pkg::ctl_t        ctl
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_CLR,
		ST_RD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign acc = in_valid && stat.room && (state_q == ST_IDLE);

	always_comb begin
		ctl = '0;
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				ctl.sweep_wr = 1'b1;
				ctl.sweep_init = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ctl.rdy = stat.room;
				if (acc) begin
					case (op)
						tccw_pkg::CMD_PUT: begin
							if (stat.at_last) begin
								ctl.push = 1'b1;
							end else if (stat.is_nl) begin
								if (stat.fill_need) begin
									ctl.fill_ld = 1'b1;
									state_d = ST_FILL;
								end else begin
									ctl.nl_cur = 1'b1;
									ctl.push = 1'b1;
								end
							end else begin
								ctl.put_wr = 1'b1;
								ctl.cur_upd = 1'b1;
								ctl.push = 1'b1;
							end
						end
						tccw_pkg::CMD_SET: begin
							ctl.cur_upd = 1'b1;
							ctl.push = 1'b1;
						end
						tccw_pkg::CMD_CLEAR: begin
							state_d = ST_CLR;
						end
						tccw_pkg::CMD_READ: begin
							ctl.rd_en = 1'b1;
							state_d = ST_RD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_FILL: begin
				ctl.fill_wr = 1'b1;
				if (stat.fill_last) begin
					ctl.nl_cur = 1'b1;
					ctl.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLR: begin
				ctl.sweep_wr = 1'b1;
				if (stat.sweep_last) begin
					ctl.home = 1'b1;
					ctl.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				ctl.push_rd = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ src/tccw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccw_datapath #(
	parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tccw_pkg::in_req_t in_data,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	input  wire tccw_pkg::ctl_t    ctl,
	output wire tccw_pkg::stat_t   stat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tccw_pkg::out_req_t     out_data
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(DEPTH);

	logic [7:0]  cols_q;
	logic [6:0]  rows_q;
	logic [15:0] attr_q;
	logic [6:0]  indent_q;

	logic [7:0]  cur_col_q;
	logic [6:0]  cur_row_q;
	logic [7:0]  fill_col_q;
	logic [AW-1:0] sweep_q;

	logic [8:0] cols;
	logic [7:0] rows;
	logic [8:0] cols_m1;
	logic [7:0] rows_m1;
	logic [8:0] col_x;
	logic [7:0] row_x;
	logic [8:0] inc_col;
	logic [7:0] row_inc;
	logic [7:0] row8;
	logic       on_screen;

	logic [7:0] nxt_col;
	logic [6:0] nxt_row;

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;
	logic        rd_ok_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic [23:0] wdata;

	tccw_pkg::out_req_t res;
	tccw_pkg::out_req_t skid_q;
	logic skid_v_q;
	logic push;
	logic pop;

	function automatic logic [AW-1:0] cell_addr(input logic [7:0] c, input logic [6:0] r);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tccw_pkg::COLS_RESET;
			rows_q <= tccw_pkg::ROWS_RESET;
			attr_q <= tccw_pkg::ATTR_RESET;
			indent_q <= tccw_pkg::INDENT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tccw_pkg::REG_SCREEN_COLS: cols_q <= cfg_data[7:0];
				tccw_pkg::REG_SCREEN_ROWS: rows_q <= cfg_data[6:0];
				tccw_pkg::REG_TEXT_ATTR:   attr_q <= cfg_data;
				tccw_pkg::REG_INDENT_COL:  indent_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// saturated screen size in use
	always_comb begin
		if (cols_q == 8'd0) begin
			cols = 9'd1;
		end else if ({1'b0, cols_q} > 9'(MAX_COLS)) begin
			cols = 9'(MAX_COLS);
		end else begin
			cols = {1'b0, cols_q};
		end
		if (rows_q == 7'd0) begin
			rows = 8'd1;
		end else if ({1'b0, rows_q} > 8'(MAX_ROWS)) begin
			rows = 8'(MAX_ROWS);
		end else begin
			rows = {1'b0, rows_q};
		end
	end

	assign cols_m1 = cols - 9'd1;
	assign rows_m1 = rows - 8'd1;
	assign col_x = {1'b0, cur_col_q};
	assign row_x = {1'b0, cur_row_q};
	assign inc_col = col_x + 9'd1;
	assign row_inc = row_x + 8'd1;
	assign on_screen = (col_x < cols) && (row_x < rows);

	assign stat.room = !skid_v_q;
	assign stat.is_nl = (in_data.char_code == tccw_pkg::CH_NEWLINE);
	assign stat.at_last = (col_x >= cols_m1) && (row_x >= rows_m1);
	assign stat.fill_need = on_screen;
	assign stat.fill_last = ({1'b0, fill_col_q} == cols_m1);
	assign stat.sweep_last = (sweep_q == AW'(DEPTH - 1));

	always_comb begin
		nxt_col = cur_col_q;
		nxt_row = cur_row_q;
		row8 = row_x;
		if (ctl.home) begin
			nxt_col = {1'b0, indent_q};
			nxt_row = '0;
		end else if (ctl.nl_cur) begin
			nxt_col = {1'b0, indent_q};
			nxt_row = (row_inc > rows_m1) ? rows_m1[6:0] : row_inc[6:0];
		end else if (ctl.cur_upd) begin
			if (in_data.cmd == tccw_pkg::CMD_SET) begin
				if ({1'b0, in_data.pos_x} <= cols) begin
					nxt_col = in_data.pos_x;
				end
				if ({1'b0, in_data.pos_y} <= rows) begin
					nxt_row = in_data.pos_y;
				end
			end else if (on_screen) begin
				if (inc_col >= cols) begin
					nxt_col = {1'b0, indent_q};
					row8 = row_inc;
				end else begin
					nxt_col = inc_col[7:0];
				end
				nxt_row = (row8 >= rows) ? rows_m1[6:0] : row8[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			sweep_q <= '0;
		end else begin
			cur_col_q <= nxt_col;
			cur_row_q <= nxt_row;
			if (ctl.sweep_wr) begin
				sweep_q <= stat.sweep_last ? '0 : sweep_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fill_ld) begin
			fill_col_q <= cur_col_q;
		end else if (ctl.fill_wr) begin
			fill_col_q <= fill_col_q + 8'd1;
		end
	end

	// single write port: init/clear sweep, newline fill or char write
	always_comb begin
		we = 1'b0;
		waddr = cell_addr(cur_col_q, cur_row_q);
		wdata = {attr_q, in_data.char_code};
		if (ctl.sweep_wr) begin
			we = 1'b1;
			waddr = sweep_q;
			wdata = {ctl.sweep_init ? tccw_pkg::ATTR_RESET : attr_q, tccw_pkg::CH_SPACE};
		end else if (ctl.fill_wr) begin
			we = 1'b1;
			waddr = cell_addr(fill_col_q, cur_row_q);
			wdata = {attr_q, tccw_pkg::CH_SPACE};
		end else if (ctl.put_wr && on_screen) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[cell_addr(in_data.pos_x, in_data.pos_y)];
			rd_ok_q <= ({1'b0, in_data.pos_x} < cols) && ({1'b0, in_data.pos_y} < rows);
		end
	end

	always_comb begin
		res.cursor_col = nxt_col;
		res.cursor_row = nxt_row;
		res.cell_char = '0;
		res.cell_attr = '0;
		if (ctl.push_rd && rd_ok_q) begin
			res.cell_char = rdata_q[7:0];
			res.cell_attr = rdata_q[23:8];
		end
	end

	// two-entry result buffer: head drives the port, skid catches the next
	assign push = ctl.push || ctl.push_rd;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				out_valid <= push;
			end
		end else if (push) begin
			if (out_valid) begin
				skid_v_q <= 1'b1;
			end else begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_data <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_data <= res;
			end
		end else if (push) begin
			if (out_valid) begin
				skid_q <= res;
			end else begin
				out_data <= res;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/text_console_cell_writer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Character-cell text console writer.
// in channel: one request per command (put char, set cursor, clear, read cell);
// every request yields exactly one out request carrying the cursor after it,
// plus the addressed cell for read cell.
// cfg channel: register writes, always ready; write only while no request is
// in flight.
// Put of an ordinary byte and set cursor push their result on acceptance, one
// per cycle sustained while in_ready is high (one cell write per cycle on the
// store's single write port). Read cell registers the read, then pushes from
// ST_RD. Newline on screen blanks the cols - cursor column cells up to the
// right edge, one per cycle. Clear sweeps all MAX_COLS*MAX_ROWS cells, one per
// cycle after the accept. Reset: the cursor homes and the store is swept to
// spaces with attribute 7, MAX_COLS*MAX_ROWS cells (8192 by default) with
// in_ready low. Output stall: a two-entry result buffer keeps one more
// request going while the head waits; in_ready drops once both entries are full.

module text_console_cell_writer_core #(
	parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tccw_pkg::in_req_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tccw_pkg::out_req_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	tccw_pkg::ctl_t  ctl;
	tccw_pkg::stat_t stat;

	assign in_ready = ctl.rdy;
	assign cfg_ready = 1'b1;

	tccw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (in_data.cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	tccw_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_read_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.cmd == tccw_pkg::CMD_READ) |=> ctl.push_rd)
		else $error("read cell did not return its result");

	a_sweep_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sweep_wr |-> (!in_ready && !ctl.fill_wr && !ctl.put_wr))
		else $error("store sweep overlaps another write or an accept");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push || ctl.push_rd) |-> (stat.room || (out_valid && out_ready)))
		else $error("result pushed into a full buffer");

endmodule

`default_nettype wire

@@ tb/sv/tb_text_console_cell_writer_core.sv @@
`timescale 1ns / 1ps

module tb_text_console_cell_writer_core;
	import tccw_pkg::*;

	localparam int COLS_MAX = MAX_COLS_DEF;
	localparam int ROWS_MAX = MAX_ROWS_DEF;
	localparam int STORE_CELLS = COLS_MAX * ROWS_MAX;
	localparam int CYCLE_LIMIT = 1_000_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_req_t     in_data;
	logic        out_valid;
	logic        out_ready;
	out_req_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	text_console_cell_writer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the screen, cursor and registers
	logic [23:0] screen_mem [STORE_CELLS];
	logic [7:0]  cur_col;
	logic [6:0]  cur_row;
	logic [7:0]  cols_reg;
	logic [6:0]  rows_reg;
	logic [15:0] attr_reg;
	logic [6:0]  indent_reg;

	out_req_t console_replies_q [$];

	int  mismatches;
	int  n_puts;
	int  n_sets;
	int  n_clears;
	int  n_reads;
	int  n_screens;
	int  hold_left;
	int  cycles;
	bit  gaps_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int cols_in_use();
		if (cols_reg == 8'd0) return 1;
		if (int'(cols_reg) > COLS_MAX) return COLS_MAX;
		return int'(cols_reg);
	endfunction

	function automatic int rows_in_use();
		if (rows_reg == 7'd0) return 1;
		if (int'(rows_reg) > ROWS_MAX) return ROWS_MAX;
		return int'(rows_reg);
	endfunction

	function automatic void blank_screen(logic [15:0] attr);
		for (int i = 0; i < STORE_CELLS; i++) screen_mem[i] = {attr, CH_SPACE};
	endfunction

	function automatic void write_cell(int c, int r, logic [7:0] ch);
		if (c < COLS_MAX && r < ROWS_MAX) screen_mem[r * COLS_MAX + c] = {attr_reg, ch};
	endfunction

	function automatic out_req_t console_step(in_req_t rq);
		out_req_t res;
		int cols;
		int rows;
		int col;
		int row;
		int c;
		cols = cols_in_use();
		rows = rows_in_use();
		col = int'(cur_col);
		row = int'(cur_row);
		res = '0;
		case (op_t'(rq.cmd))
			CMD_PUT: begin
				// nothing happens once the cursor sits on the last cell
				if (!(col >= cols - 1 && row >= rows - 1)) begin
					if (rq.char_code == CH_NEWLINE) begin
						if (row < rows)
							for (c = col; c < cols; c++) write_cell(c, row, CH_SPACE);
						col = int'(indent_reg);
						row = (row + 1 > rows - 1) ? rows - 1 : row + 1;
					end else if (col < cols && row < rows) begin
						write_cell(col, row, rq.char_code);
						col++;
						if (col >= cols) begin
							col = int'(indent_reg);
							row++;
						end
						if (row >= rows) row = rows - 1;
					end
				end
			end
			CMD_SET: begin
				if (int'(rq.pos_x) <= cols) col = int'(rq.pos_x);
				if (int'(rq.pos_y) <= rows) row = int'(rq.pos_y);
			end
			CMD_CLEAR: begin
				blank_screen(attr_reg);
				col = int'(indent_reg);
				row = 0;
			end
			default: begin
				if (int'(rq.pos_x) < cols && int'(rq.pos_y) < rows) begin
					c = int'(rq.pos_y) * COLS_MAX + int'(rq.pos_x);
					res.cell_char = screen_mem[c][7:0];
					res.cell_attr = screen_mem[c][23:8];
				end
			end
		endcase
		cur_col = col[7:0];
		cur_row = row[6:0];
		res.cursor_col = cur_col;
		res.cursor_row = cur_row;
		return res;
	endfunction

	function automatic in_req_t random_command();
		in_req_t rq;
		int pick;
		int cols;
		int rows;
		cols = cols_in_use();
		rows = rows_in_use();
		rq.char_code = 8'($urandom);
		rq.pos_x = 8'($urandom);
		rq.pos_y = 7'($urandom);
		pick = $urandom_range(0, 199);
		if (pick < 3) begin
			rq.cmd = CMD_CLEAR;
		end else if (pick < 30) begin
			rq.cmd = CMD_SET;
			if (pick < 26) begin
				rq.pos_x = 8'($urandom_range(0, cols));
				rq.pos_y = 7'($urandom_range(0, rows));
			end
		end else if (pick < 65) begin
			rq.cmd = CMD_READ;
			if (pick < 60) begin
				rq.pos_x = 8'($urandom_range(0, cols - 1));
				rq.pos_y = 7'($urandom_range(0, rows - 1));
			end
		end else begin
			rq.cmd = CMD_PUT;
			if (pick < 85) rq.char_code = CH_NEWLINE;
			else if (pick < 185) rq.char_code = 8'($urandom_range(32, 126));
		end
		return rq;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic send_cmd(in_req_t rq);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = rq;
		do @(posedge clk); while (!in_ready);
		console_replies_q.push_back(console_step(rq));
		case (op_t'(rq.cmd))
			CMD_PUT:   n_puts++;
			CMD_SET:   n_sets++;
			CMD_CLEAR: n_clears++;
			default:   n_reads++;
		endcase
	endtask

	task automatic issue(op_t op, logic [7:0] ch, logic [7:0] x, logic [6:0] y);
		in_req_t rq;
		rq.cmd = op;
		rq.char_code = ch;
		rq.pos_x = x;
		rq.pos_y = y;
		send_cmd(rq);
	endtask

	task automatic send_random(int count);
		repeat (count) send_cmd(random_command());
	endtask

	task automatic drain_replies();
		@(negedge clk);
		in_valid = 1'b0;
		while (console_replies_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SCREEN_COLS: cols_reg = value[7:0];
			REG_SCREEN_ROWS: rows_reg = value[6:0];
			REG_TEXT_ATTR:   attr_reg = value;
			default:         indent_reg = value[6:0];
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_screen(logic [15:0] cols_w, logic [15:0] rows_w, logic [15:0] attr_w,
			logic [15:0] indent_w);
		drain_replies();
		write_reg(REG_SCREEN_COLS, cols_w);
		write_reg(REG_SCREEN_ROWS, rows_w);
		write_reg(REG_TEXT_ATTR, attr_w);
		write_reg(REG_INDENT_COL, indent_w);
		n_screens++;
	endtask

	task automatic test_reset_screen();
		issue(CMD_READ, 8'h00, 8'd0, 7'd0);
		issue(CMD_PUT, 8'h48, 8'd0, 7'd0);
		issue(CMD_PUT, 8'h00, 8'd0, 7'd0);
		issue(CMD_PUT, 8'hFF, 8'd0, 7'd0);
		issue(CMD_PUT, CH_NEWLINE, 8'd0, 7'd0);
		issue(CMD_READ, 8'h00, 8'd2, 7'd0);
		issue(CMD_READ, 8'h00, 8'd3, 7'd0);
		issue(CMD_SET, 8'h00, 8'd10, 7'd100);
		issue(CMD_SET, 8'h00, 8'd80, 7'd25);
		issue(CMD_PUT, 8'h78, 8'd0, 7'd0);
		issue(CMD_SET, 8'h00, 8'd81, 7'd26);
		issue(CMD_SET, 8'h00, 8'd255, 7'd127);
		// newline with the cursor past the right edge
		issue(CMD_SET, 8'h00, 8'd80, 7'd3);
		issue(CMD_PUT, CH_NEWLINE, 8'd0, 7'd0);
		issue(CMD_SET, 8'h00, 8'd79, 7'd0);
		issue(CMD_PUT, 8'h5A, 8'd0, 7'd0);
		issue(CMD_SET, 8'h00, 8'd78, 7'd24);
		issue(CMD_PUT, 8'h61, 8'd0, 7'd0);
		issue(CMD_PUT, 8'h62, 8'd0, 7'd0);
		issue(CMD_SET, 8'h00, 8'd5, 7'd24);
		issue(CMD_PUT, CH_NEWLINE, 8'd0, 7'd0);
		issue(CMD_READ, 8'h00, 8'd78, 7'd24);
		issue(CMD_READ, 8'h00, 8'd80, 7'd0);
		issue(CMD_READ, 8'h00, 8'd0, 7'd25);
		issue(CMD_READ, 8'h00, 8'd255, 7'd127);
		issue(CMD_CLEAR, 8'h00, 8'd0, 7'd0);
		issue(CMD_READ, 8'h00, 8'd79, 7'd0);
	endtask

	task automatic test_tiny_screens();
		// zero sizes saturate to one
		set_screen(16'hFF00, 16'hFF80, 16'h1234, 16'h0000);
		send_random(15);
		set_screen(16'd1, 16'd2, 16'hC3A5, 16'd0);
		send_random(15);
	endtask

	task automatic test_full_screens();
		// oversized registers saturate to the full store
		set_screen(16'hAB81, 16'hFFC1, 16'hFFFF, 16'hFF7F);
		send_random(20);
		set_screen(16'd128, 16'd64, 16'h0000, 16'd0);
		send_random(20);
	endtask

	task automatic test_indent_past_edge();
		set_screen(16'd4, 16'd3, 16'h5A5A, 16'd10);
		for (int i = 0; i < 6; i++) issue(CMD_PUT, 8'h41 + 8'(i), 8'd0, 7'd0);
		issue(CMD_PUT, CH_NEWLINE, 8'd0, 7'd0);
		issue(CMD_PUT, CH_NEWLINE, 8'd0, 7'd0);
		issue(CMD_READ, 8'h00, 8'd3, 7'd0);
		issue(CMD_READ, 8'h00, 8'd0, 7'd1);
		issue(CMD_SET, 8'h00, 8'd4, 7'd3);
		issue(CMD_READ, 8'h00, 8'd4, 7'd0);
		send_random(12);
	endtask

	task automatic test_resize();
		set_screen(16'd8, 16'd4, 16'h0F0F, 16'd0);
		repeat (20) issue(CMD_PUT, 8'($urandom_range(32, 126)), 8'($urandom), 7'($urandom));
		// shrinking leaves cells and cursor where they were
		set_screen(16'd3, 16'd2, 16'hF0F0, 16'd1);
		repeat (8) issue(CMD_READ, 8'($urandom), 8'($urandom_range(0, 8)),
			7'($urandom_range(0, 4)));
		send_random(10);
	endtask

	task automatic test_random_text();
		int c;
		int r;
		repeat (6) begin
			if ($urandom_range(0, 3) == 0) begin
				c = $urandom_range(0, 255);
				r = $urandom_range(0, 127);
			end else begin
				c = $urandom_range(1, 20);
				r = $urandom_range(1, 6);
			end
			set_screen({8'($urandom), 8'(c)}, {9'($urandom), 7'(r)}, 16'($urandom),
				$urandom_range(0, 7) == 0 ? 16'($urandom)
					: {9'($urandom), 7'($urandom_range(0, c > 127 ? 127 : c))});
			send_random(45);
		end
	endtask

	task automatic test_output_stall();
		set_screen(16'd12, 16'd5, 16'h00AA, 16'd2);
		gaps_on = 1'b0;
		hold_left = 400;
		send_random(12);
	endtask

	task automatic test_unthrottled();
		set_screen(16'd10, 16'd4, 16'h55AA, 16'd0);
		gaps_on = 1'b0;
		send_random(40);
	endtask

	initial begin : reply_sink
		int burst;
		burst = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_ready = 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 17) - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : reply_check
		out_req_t want;
		if (arst_n && out_valid && out_ready) begin
			if (console_replies_q.size() == 0) begin
				mismatches++;
				$display("%0t: unrequested reply, expected none, actual %p", $time, out_data);
			end else begin
				want = console_replies_q.pop_front();
				check_field("cell_char", want.cell_char, out_data.cell_char);
				check_field("cell_attr", want.cell_attr, out_data.cell_attr);
				check_field("cursor_col", want.cursor_col, out_data.cursor_col);
				check_field("cursor_row", want.cursor_row, out_data.cursor_row);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d replies outstanding", cycles,
			console_replies_q.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCREEN_COLS;
		cfg_data = '0;
		gaps_on = 1'b1;
		hold_left = 0;
		mismatches = 0;
		n_puts = 0;
		n_sets = 0;
		n_clears = 0;
		n_reads = 0;
		n_screens = 1;
		blank_screen(ATTR_RESET);
		cur_col = '0;
		cur_row = '0;
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		attr_reg = ATTR_RESET;
		indent_reg = INDENT_RESET;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_screen();
		test_tiny_screens();
		test_full_screens();
		test_indent_past_edge();
		test_resize();
		test_random_text();
		test_output_stall();
		test_unthrottled();

		drain_replies();
		repeat (20) @(posedge clk);
		$display("Sent %0d put char, %0d set cursor, %0d clear and %0d read cell commands",
			n_puts, n_sets, n_clears, n_reads);
		$display("over %0d screen settings, with input gaps, output stalls and a long hold-off",
			n_screens);
		if (mismatches == 0 && console_replies_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ text_console_cell_writer_core.f @@
src/tccw_pkg.sv
src/tccw_ctrl.sv
src/tccw_datapath.sv
src/text_console_cell_writer_core.sv
tb/sv/tb_text_console_cell_writer_core.sv
